>>> rtl/tsk_pkg.sv
// tsk_pkg: shared types and constants of the topological sort engine
// transaction payload structs, command codes and the stored edge record
// no dependencies
package tsk_pkg;

    localparam int NODE_W = 5;
    localparam int CFG_W  = 6;
    localparam int CNT_W  = 6;

    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_RUN      = 1'b1;

    typedef struct packed {
        logic              command;
        logic [NODE_W-1:0] src_node;
        logic [NODE_W-1:0] dst_node;
    } item_t;

    typedef struct packed {
        logic [NODE_W-1:0] node_index;
        logic              is_done;
        logic [CNT_W-1:0]  emitted_count;
        logic              edge_overflow;
    } result_t;

    typedef struct packed {
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
    } edge_t;

endpackage

>>> rtl/topological_sort_kahn.sv
// topological_sort_kahn: edge loader and kahn sort sequencer
// uses tsk_pkg (types, codes) and tsk_ram (edge, in-degree and ready queue rams)
//
//   channel   signals                            direction  carries
//   item      item_valid / item_ready / item     in         add-edge or run command
//   result    result_valid / result_ready / result out      emitted node or done summary
//   cfg       cfg_valid / cfg_ready / cfg_data   in         node_count register write
//
// add-edge transactions are taken in the idle state, so edges can be loaded every cycle while no run is in progress
// during a run every popped node rescans the whole edge ram, reading the in-degree ram for
// each edge and writing back a decremented in-degree for the edges that leave that node
// no item transaction is taken during a run; result stalls only hold the emit and done steps
// reset clears control state; the rams are not cleared and need no clearing pass
module topological_sort_kahn #(
    parameter int MAX_NODES = 32,
    parameter int MAX_EDGES = 128
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  tsk_pkg::item_t               item,
    output logic                         result_valid,
    input  logic                         result_ready,
    output tsk_pkg::result_t             result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tsk_pkg::CFG_W-1:0]    cfg_data
);

    // widths derived from the sizing parameters
    localparam int NW  = $clog2(MAX_NODES);                        // node address
    localparam int CW  = $clog2(MAX_NODES + 1);                    // node counters
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;  // edge address
    localparam int EHW = $clog2(MAX_EDGES + 1);                    // edge counters
    localparam int DW  = EHW;                                      // in-degree value

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLR     = 4'd1;
    localparam logic [3:0] S_CNT_RD  = 4'd2;
    localparam logic [3:0] S_CNT_A   = 4'd3;
    localparam logic [3:0] S_CNT_B   = 4'd4;
    localparam logic [3:0] S_SEED    = 4'd5;
    localparam logic [3:0] S_POP     = 4'd6;
    localparam logic [3:0] S_POP_W   = 4'd7;
    localparam logic [3:0] S_SCAN_RD = 4'd8;
    localparam logic [3:0] S_SCAN_A  = 4'd9;
    localparam logic [3:0] S_SCAN_B  = 4'd10;
    localparam logic [3:0] S_EMIT    = 4'd11;
    localparam logic [3:0] S_FIN     = 4'd12;

    // control registers
    logic [3:0]                state_reg, state_next;
    logic [tsk_pkg::CFG_W-1:0] node_count_reg, node_count_next;
    logic [EHW-1:0]            edges_held_reg, edges_held_next;
    logic                      overflow_reg, overflow_next;
    logic [CW-1:0]             v_reg, v_next;
    logic                      pend_reg, pend_next;
    logic [EHW-1:0]            e_reg, e_next;
    logic [CW-1:0]             head_reg, head_next;
    logic [CW-1:0]             tail_reg, tail_next;
    logic                      out_valid_reg, out_valid_next;

    // payload registers
    logic [NW-1:0]             pend_idx_reg, pend_idx_next;
    logic [NW-1:0]             u_reg, u_next;
    logic                      match_reg, match_next;
    logic [NW-1:0]             dst_reg, dst_next;
    tsk_pkg::result_t          out_reg, out_next;

    // ram ports
    logic                      edge_wr_en, edge_rd_en;
    logic [EAW-1:0]            edge_wr_addr, edge_rd_addr;
    tsk_pkg::edge_t            edge_wr_data, edge_rd_data;
    logic                      deg_wr_en, deg_rd_en;
    logic [NW-1:0]             deg_wr_addr, deg_rd_addr;
    logic [DW-1:0]             deg_wr_data, deg_rd_data;
    logic                      q_wr_en, q_rd_en;
    logic [NW-1:0]             q_wr_addr, q_rd_addr;
    logic [NW-1:0]             q_wr_data, q_rd_data;

    // helpers
    logic [tsk_pkg::CFG_W-1:0] n_eff;
    logic                      item_take;
    logic                      out_free;
    logic                      rd_edge_live;
    logic                      rd_edge_from_u;

    // edge store: one record per loaded edge, in arrival order
    tsk_ram #(
        .DEPTH (MAX_EDGES),
        .WIDTH ($bits(tsk_pkg::edge_t))
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (edge_wr_en),
        .wr_addr (edge_wr_addr),
        .wr_data (edge_wr_data),
        .rd_en   (edge_rd_en),
        .rd_addr (edge_rd_addr),
        .rd_data (edge_rd_data)
    );

    // in-degree table, rebuilt at the start of each run
    tsk_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (DW)
    ) u_deg_ram (
        .clk     (clk),
        .wr_en   (deg_wr_en),
        .wr_addr (deg_wr_addr),
        .wr_data (deg_wr_data),
        .rd_en   (deg_rd_en),
        .rd_addr (deg_rd_addr),
        .rd_data (deg_rd_data)
    );

    // ready queue, fifo through head and tail counters
    tsk_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (NW)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (q_wr_addr),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_addr (q_rd_addr),
        .rd_data (q_rd_data)
    );

    // node count clamped to the table size
    assign n_eff = (node_count_reg > tsk_pkg::CFG_W'(MAX_NODES))
                 ? tsk_pkg::CFG_W'(MAX_NODES) : node_count_reg;

    assign item_ready   = (state_reg == S_IDLE);
    assign item_take    = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign out_free     = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // edge record just read: both endpoints inside the current graph
    assign rd_edge_live = (tsk_pkg::CFG_W'(edge_rd_data.src) < n_eff)
                       && (tsk_pkg::CFG_W'(edge_rd_data.dst) < n_eff);
    // edge record just read leaves the node being expanded
    assign rd_edge_from_u = (tsk_pkg::CFG_W'(edge_rd_data.src) == tsk_pkg::CFG_W'(u_reg))
                         && (tsk_pkg::CFG_W'(edge_rd_data.dst) < n_eff);

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        edges_held_next = edges_held_reg;
        overflow_next   = overflow_reg;
        v_next          = v_reg;
        pend_next       = pend_reg;
        e_next          = e_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        out_valid_next  = out_valid_reg;
        pend_idx_next   = pend_idx_reg;
        u_next          = u_reg;
        match_next      = match_reg;
        dst_next        = dst_reg;
        out_next        = out_reg;

        edge_wr_en       = 1'b0;
        edge_wr_addr     = edges_held_reg[EAW-1:0];
        edge_wr_data.src = item.src_node;
        edge_wr_data.dst = item.dst_node;
        edge_rd_en       = 1'b0;
        edge_rd_addr     = e_reg[EAW-1:0];
        deg_wr_en        = 1'b0;
        deg_wr_addr      = dst_reg;
        deg_wr_data      = '0;
        deg_rd_en        = 1'b0;
        deg_rd_addr      = NW'(edge_rd_data.dst);
        q_wr_en          = 1'b0;
        q_wr_addr        = tail_reg[NW-1:0];
        q_wr_data        = dst_reg;
        q_rd_en          = 1'b0;
        q_rd_addr        = head_reg[NW-1:0];

        if (cfg_valid && cfg_ready)
        begin
            node_count_next = cfg_data;
        end

        // output register drains independently of the sequencer
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_take)
                begin
                    if (item.command == tsk_pkg::CMD_RUN)
                    begin
                        v_next     = '0;
                        head_next  = '0;
                        tail_next  = '0;
                        state_next = S_CLR;
                    end
                    else if ((edges_held_reg == EHW'(MAX_EDGES))
                          || (tsk_pkg::CFG_W'(item.src_node) >= n_eff)
                          || (tsk_pkg::CFG_W'(item.dst_node) >= n_eff))
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        edge_wr_en      = 1'b1;
                        edges_held_next = edges_held_reg + EHW'(1);
                    end
                end
            end

            // zero the in-degree of every live node
            S_CLR:
            begin
                if (tsk_pkg::CFG_W'(v_reg) < n_eff)
                begin
                    deg_wr_en   = 1'b1;
                    deg_wr_addr = v_reg[NW-1:0];
                    v_next      = v_reg + CW'(1);
                end
                else
                begin
                    e_next     = '0;
                    state_next = S_CNT_RD;
                end
            end

            S_CNT_RD:
            begin
                if (e_reg < edges_held_reg)
                begin
                    edge_rd_en = 1'b1;
                    state_next = S_CNT_A;
                end
                else
                begin
                    v_next     = '0;
                    pend_next  = 1'b0;
                    state_next = S_SEED;
                end
            end

            // edge record ready: fetch the target's in-degree
            S_CNT_A:
            begin
                match_next = rd_edge_live;
                dst_next   = NW'(edge_rd_data.dst);
                deg_rd_en  = 1'b1;
                e_next     = e_reg + EHW'(1);
                state_next = S_CNT_B;
            end

            // in-degree ready: count the edge, overlap the next edge fetch
            S_CNT_B:
            begin
                if (match_reg)
                begin
                    deg_wr_en   = 1'b1;
                    deg_wr_data = deg_rd_data + DW'(1);
                end
                if (e_reg < edges_held_reg)
                begin
                    edge_rd_en = 1'b1;
                    state_next = S_CNT_A;
                end
                else
                begin
                    v_next     = '0;
                    pend_next  = 1'b0;
                    state_next = S_SEED;
                end
            end

            // queue the sources in index order, one read per cycle in flight
            S_SEED:
            begin
                if (pend_reg && (deg_rd_data == '0))
                begin
                    q_wr_en   = 1'b1;
                    q_wr_data = pend_idx_reg;
                    tail_next = tail_reg + CW'(1);
                end
                if (tsk_pkg::CFG_W'(v_reg) < n_eff)
                begin
                    deg_rd_en     = 1'b1;
                    deg_rd_addr   = v_reg[NW-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = v_reg[NW-1:0];
                    v_next        = v_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_POP;
                    end
                end
            end

            S_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    q_rd_en    = 1'b1;
                    head_next  = head_reg + CW'(1);
                    state_next = S_POP_W;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_POP_W:
            begin
                u_next     = q_rd_data;
                e_next     = '0;
                state_next = S_SCAN_RD;
            end

            S_SCAN_RD:
            begin
                if (e_reg < edges_held_reg)
                begin
                    edge_rd_en = 1'b1;
                    state_next = S_SCAN_A;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_SCAN_A:
            begin
                match_next = rd_edge_from_u;
                dst_next   = NW'(edge_rd_data.dst);
                deg_rd_en  = 1'b1;
                e_next     = e_reg + EHW'(1);
                state_next = S_SCAN_B;
            end

            // decrement the successor, queue it when it reaches zero
            S_SCAN_B:
            begin
                if (match_reg && (deg_rd_data != '0))
                begin
                    deg_wr_en   = 1'b1;
                    deg_wr_data = deg_rd_data - DW'(1);
                    if (deg_rd_data == DW'(1))
                    begin
                        q_wr_en   = 1'b1;
                        tail_next = tail_reg + CW'(1);
                    end
                end
                if (e_reg < edges_held_reg)
                begin
                    edge_rd_en = 1'b1;
                    state_next = S_SCAN_A;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.node_index    = tsk_pkg::NODE_W'(u_reg);
                    out_next.is_done       = 1'b0;
                    out_next.emitted_count = '0;
                    out_next.edge_overflow = overflow_reg;
                    state_next             = S_POP;
                end
            end

            // done summary; the edge store and flag are released in the same step
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.node_index    = '0;
                    out_next.is_done       = 1'b1;
                    out_next.emitted_count = tsk_pkg::CNT_W'(head_reg);
                    out_next.edge_overflow = overflow_reg;
                    edges_held_next        = '0;
                    overflow_next          = 1'b0;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= tsk_pkg::CFG_W'(1);
            edges_held_reg <= '0;
            overflow_reg   <= 1'b0;
            v_reg          <= '0;
            pend_reg       <= 1'b0;
            e_reg          <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            edges_held_reg <= edges_held_next;
            overflow_reg   <= overflow_next;
            v_reg          <= v_next;
            pend_reg       <= pend_next;
            e_reg          <= e_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        u_reg        <= u_next;
        match_reg    <= match_next;
        dst_reg      <= dst_next;
        out_reg      <= out_next;
    end

endmodule

>>> rtl/tsk_ram.sv
// tsk_ram: simple dual-port synchronous ram, one write and one read port
// read data registered
// no dependencies
module tsk_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
